@@ hw/rtl/calc_charset_to_ascii_escaper_unit_macros.svh @@
// Assertion macros shared by the escaper unit.
`ifndef CALC_CHARSET_TO_ASCII_ESCAPER_UNIT_MACROS_SVH
`define CALC_CHARSET_TO_ASCII_ESCAPER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on every edge outside reset.
`define CCE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every edge, reset included.
`define CCE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CCE_ASSERT(lbl, clk, rst, prop, msg)
`define CCE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

@@ hw/rtl/cce_pkg.sv @@
package cce_pkg;

   localparam int CCE_QUEUE_DEPTH = 4;
   localparam int CCE_MAX_RUN     = 7;

   localparam logic [7:0] CCE_FOLD_FROM = 8'd130;
   localparam logic [7:0] CCE_LF_CODE   = 8'd138;
   localparam logic [7:0] CCE_LOW_MASK  = 8'd127;

   // Escape text, first byte in the top slot.
   typedef logic [CCE_MAX_RUN-1:0][7:0] cce_text_type;

   typedef struct packed {
      logic [2:0]   len;
      cce_text_type text;
      logic         eot;
   } cce_entry_type;

   function automatic cce_entry_type cce_mk(input logic [2:0] len, input cce_text_type text,
                                            input logic eot);
      cce_entry_type e;
      e.len  = len;
      e.text = text;
      e.eot  = eot;
      return e;
   endfunction

   // Fold the code and look up its escape run.
   function automatic cce_entry_type cce_classify(input logic [7:0] raw, input logic eot);
      logic [7:0]    code;
      cce_entry_type e;
      code = raw;
      if (raw >= CCE_FOLD_FROM && raw != CCE_LF_CODE) begin
         code = raw & CCE_LOW_MASK;
      end
      case (code)
         8'd0:   e = cce_mk(3'd1, {8'd247, 48'h0}, eot);
         8'd1:   e = cce_mk(3'd1, {8'd215, 48'h0}, eot);
         8'd2:   e = cce_mk(3'd5, {"\\sqrt", 16'h0}, eot);
         8'd3:   e = cce_mk(3'd4, {"\\int", 24'h0}, eot);
         8'd4:   e = cce_mk(3'd6, {"\\gray1", 8'h0}, eot);
         8'd5:   e = cce_mk(3'd6, {"\\Sigma", 8'h0}, eot);
         8'd6:   e = cce_mk(3'd1, {">", 48'h0}, eot);
         8'd7:   e = cce_mk(3'd3, {"\\pi", 32'h0}, eot);
         8'd8:   e = cce_mk(3'd1, {8'd191, 48'h0}, eot);
         8'd9:   e = cce_mk(3'd2, {"<=", 40'h0}, eot);
         8'd11:  e = cce_mk(3'd2, {">=", 40'h0}, eot);
         8'd12:  e = cce_mk(3'd2, {"!=", 40'h0}, eot);
         8'd13:  e = cce_mk(3'd2, {"\\r", 40'h0}, eot);
         8'd14:  e = cce_mk(3'd1, {"v", 48'h0}, eot);
         8'd15:  e = cce_mk(3'd2, {"->", 40'h0}, eot);
         8'd16:  e = cce_mk(3'd2, {"<-", 40'h0}, eot);
         8'd17:  e = cce_mk(3'd1, {8'd181, 48'h0}, eot);
         8'd18:  e = cce_mk(3'd1, {8'd163, 48'h0}, eot);
         8'd19:  e = cce_mk(3'd1, {8'd176, 48'h0}, eot);
         8'd20:  e = cce_mk(3'd1, {8'd197, 48'h0}, eot);
         8'd21:  e = cce_mk(3'd1, {8'd209, 48'h0}, eot);
         8'd22:  e = cce_mk(3'd1, {8'd196, 48'h0}, eot);
         8'd23:  e = cce_mk(3'd6, {"\\angle", 8'h0}, eot);
         8'd24:  e = cce_mk(3'd1, {"E", 48'h0}, eot);
         8'd25:  e = cce_mk(3'd1, {8'd198, 48'h0}, eot);
         8'd26:  e = cce_mk(3'd3, {"...", 32'h0}, eot);
         8'd27:  e = cce_mk(3'd4, {"\\esc", 24'h0}, eot);
         8'd28:  e = cce_mk(3'd1, {8'd214, 48'h0}, eot);
         8'd29:  e = cce_mk(3'd1, {8'd220, 48'h0}, eot);
         8'd30:  e = cce_mk(3'd6, {"\\gray2", 8'h0}, eot);
         8'd31:  e = cce_mk(3'd7, "\\bullet", eot);
         8'd92:  e = cce_mk(3'd2, {"\\\\", 40'h0}, eot);
         8'd127: e = cce_mk(3'd2, {"|-", 40'h0}, eot);
         8'd128: e = cce_mk(3'd1, {":", 48'h0}, eot);
         8'd129: e = cce_mk(3'd1, {"y", 48'h0}, eot);
         8'd138: e = cce_mk(3'd3, {"\\LF", 32'h0}, eot);
         default: e = cce_mk(3'd1, {code, 48'h0}, eot);
      endcase
      return e;
   endfunction

endpackage

@@ hw/rtl/cce_front.sv @@
module cce_front
   import cce_pkg::*;
(
   input  logic [7:0]    in_byte,
   input  logic          end_of_text,
   output cce_entry_type entry
);

   // Fold and look up in one pass; the queue registers the result.
   assign entry = cce_classify(in_byte, end_of_text);

endmodule

@@ hw/rtl/cce_queue.sv @@
`include "calc_charset_to_ascii_escaper_unit_macros.svh"
module cce_queue
   import cce_pkg::*;
#(
   parameter int DEPTH = CCE_QUEUE_DEPTH
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cce_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          head_valid,
   output cce_entry_type head_entry
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   cce_entry_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CCE_ASSERT(a_no_overflow, clock, reset, push |-> !full, "push into a full queue")
   `CCE_ASSERT(a_no_underflow, clock, reset, pop |-> head_valid, "pop from an empty queue")
   `CCE_ASSERT(a_count_range, clock, reset, count_ff <= FULL_COUNT, "queue count out of range")
   `CCE_ASSERT(a_ptr_gap, clock, reset,
      (count_ff == '0 || count_ff == FULL_COUNT) |-> (wr_ptr_ff == rd_ptr_ff),
      "queue pointers disagree with count")

endmodule

@@ hw/rtl/cce_back.sv @@
`include "calc_charset_to_ascii_escaper_unit_macros.svh"
module cce_back
   import cce_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          head_valid,
   input  cce_entry_type head_entry,
   output logic          head_pop,
   output logic          out_empty,
   input  logic          out_pop,
   output logic [7:0]    out_byte,
   output logic          run_last,
   output logic          text_done
);

   localparam logic [2:0] TOP_SLOT = 3'(CCE_MAX_RUN - 1);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       done_ff;
   logic       load;
   logic       emit;
   logic       cur_last;

   // Refill the output register when it is empty or being drained.
   assign load     = !valid_ff || out_pop;
   assign emit     = head_valid && load;
   assign cur_last = (idx_ff == head_entry.len - 3'd1);
   assign head_pop = emit && cur_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !out_pop;
      if (emit) begin
         idx_in   = cur_last ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff <= head_entry.text[TOP_SLOT - idx_ff];
         last_ff <= cur_last;
         done_ff <= cur_last && head_entry.eot;
      end
   end

   assign out_empty = !valid_ff;
   assign out_byte  = byte_ff;
   assign run_last  = last_ff;
   assign text_done = done_ff;

   `CCE_ASSERT(a_idx_in_run, clock, reset, head_valid |-> (idx_ff < head_entry.len),
      "byte index beyond run length")
   `CCE_ASSERT(a_mid_run_held, clock, reset, (idx_ff != 3'd0) |-> head_valid,
      "run abandoned part way")
   `CCE_ASSERT(a_done_on_last, clock, reset, (valid_ff && done_ff) |-> last_ff,
      "text end flagged off a run end")
   `CCE_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (out_empty && idx_ff == 3'd0),
      "back end not idle after reset")

endmodule

@@ hw/rtl/calc_charset_to_ascii_escaper_unit.sv @@
// Channel   Ports                                         Handshake
// --------  --------------------------------------------  ---------------------------
// request   req_in_byte, req_end_of_text                  req_push & !req_full
// response  rsp_out_byte, rsp_run_last, rsp_text_done     rsp_pop & !rsp_empty
//
// Each item gives one to seven response bytes, one per cycle while rsp_pop keeps draining the output.
// The back end's byte counter keeps a run in its queue slot until the run's last byte is emitted.
// A pushed request's first byte passes through the queue write and then the output register.
// Synchronous active-high reset empties the queue and the output register; no clearing pass.
// req_full rises only when the entry queue is full; rsp_pop low stalls the back end alone.
module calc_charset_to_ascii_escaper_unit
   import cce_pkg::*;
#(
   parameter int QUEUE_DEPTH = CCE_QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_text_done
);

   cce_entry_type front_entry;
   cce_entry_type head_entry;
   logic          q_push;
   logic          q_full;
   logic          head_valid;
   logic          head_pop;

   // Classify the incoming code into a length and an escape text.
   cce_front u_front (
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .entry       (front_entry)
   );

   // Take the item only when the queue has room.
   assign q_push   = req_push && !q_full;
   assign req_full = q_full;

   // Hold classified items between front and back.
   cce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (front_entry),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // Advance through each run a byte at a time into the output register.
   cce_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .head_pop   (head_pop),
      .out_empty  (rsp_empty),
      .out_pop    (rsp_pop),
      .out_byte   (rsp_out_byte),
      .run_last   (rsp_run_last),
      .text_done  (rsp_text_done)
   );

endmodule
